>>> rtl/aff2d_pkg.sv
// Shared types, constants and the arctangent table for the 2D affine matrix builder.
package aff2d_pkg;

    // Number format of the request and result values.
    localparam int DATA_W       = 32;
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;

    // Internal CORDIC formats: angle in degrees with 24 fraction bits, vector in Q30.
    localparam int ANG_FRAC = 24;
    localparam int VEC_FRAC = 30;
    localparam int TAB_LEN  = 24;
    localparam int STEPS    = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

    // Widths of the angle accumulator and of the x/y vector.
    localparam int Z_W  = 33;
    localparam int XY_W = 33;

    // Angle reduction: the integer degrees are offset by whole turns so that the
    // division by 90 works on a non-negative value.
    localparam int H_W       = DATA_W - FRAC_BITS;
    localparam int U_W       = H_W + 1;
    localparam int ANG_OFS   = 360 * ((2 ** (H_W - 1) + 359) / 360);
    localparam int RECIP_SH  = U_W + 6;
    localparam longint RECIP = (longint'(1) <<< RECIP_SH) / 90;
    localparam int Q_W       = U_W - 6;
    localparam int R_W       = 7;

    // Gain-compensated start value of x, corrected for the step count.
    localparam longint GAIN_Q30  = 652032874;
    localparam longint GAIN_CORR = 434688582;
    localparam longint X_INIT    = GAIN_Q30 + (GAIN_CORR >>> (2 * STEPS));

    // Conversion from Q30 back to the request format, rounding half up.
    localparam int OUT_SH = VEC_FRAC - FRAC_BITS;
    localparam int RND    = 1 << (VEC_FRAC - 1 - FRAC_BITS);

    // Transform kinds.
    typedef enum logic [1:0] {
        CMD_TRANSLATE = 2'd0,
        CMD_ROTATE    = 2'd1,
        CMD_SCALE     = 2'd2
    } t_cmd;

    // One request.
    typedef struct packed {
        logic [1:0]               command;
        logic signed [DATA_W-1:0] param_a;
        logic signed [DATA_W-1:0] param_b;
    } t_req;

    // One result: the top two rows of the homogeneous matrix.
    typedef struct packed {
        logic signed [DATA_W-1:0] row0_col0;
        logic signed [DATA_W-1:0] row0_col1;
        logic signed [DATA_W-1:0] row0_col2;
        logic signed [DATA_W-1:0] row1_col0;
        logic signed [DATA_W-1:0] row1_col1;
        logic signed [DATA_W-1:0] row1_col2;
    } t_rsp;

    // atan(2^-i) in degrees, scaled by 2^24 and rounded.
    function automatic logic signed [Z_W-1:0] atan_deg(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = Z_W'(754974720);
            1:       v = Z_W'(445687602);
            2:       v = Z_W'(235489088);
            3:       v = Z_W'(119537938);
            4:       v = Z_W'(60000934);
            5:       v = Z_W'(30029717);
            6:       v = Z_W'(15018523);
            7:       v = Z_W'(7509720);
            8:       v = Z_W'(3754917);
            9:       v = Z_W'(1877466);
            10:      v = Z_W'(938734);
            11:      v = Z_W'(469367);
            12:      v = Z_W'(234684);
            13:      v = Z_W'(117342);
            14:      v = Z_W'(58671);
            15:      v = Z_W'(29335);
            16:      v = Z_W'(14668);
            17:      v = Z_W'(7334);
            18:      v = Z_W'(3667);
            19:      v = Z_W'(1833);
            20:      v = Z_W'(917);
            21:      v = Z_W'(458);
            22:      v = Z_W'(229);
            23:      v = Z_W'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/affine_2d_matrix_builder_core.sv
// Pipelined builder of the top two rows of a homogeneous 2D transform matrix.
//
//  Channel   Valid / ready        Payload            Direction
//  request   i_valid / o_ready    i_req  (t_req)     in
//  result    o_valid / i_ready    o_rsp  (t_rsp)     out
//
// One request is taken per cycle while the pipeline is not stalled; each request passes
// through two stages of angle reduction, one CORDIC iteration per stage and one
// output stage.
// Reset clears the valid bit of every stage; the data registers are not reset.
// A stage holds its request while the next one is occupied and stalled, so bubbles
// close up and the request side stalls only when every stage is full.
module affine_2d_matrix_builder_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  aff2d_pkg::t_req i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output aff2d_pkg::t_rsp o_rsp
);
    import aff2d_pkg::*;

    // Two reduction stages followed by one stage per CORDIC step.
    localparam int NP = STEPS + 2;

    localparam logic signed [DATA_W-1:0] ONE       = DATA_W'(longint'(1) <<< FRAC_BITS);
    localparam logic signed [Z_W-1:0]    QUARTER_Z = Z_W'(longint'(90) <<< ANG_FRAC);

    // Contents of one pipeline stage.
    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic [U_W-1:0]           u;
        logic [Q_W-1:0]           q;
        logic [1:0]               quad;
        logic signed [XY_W-1:0]   x;
        logic signed [XY_W-1:0]   y;
        logic signed [Z_W-1:0]    z;
    } t_pipe;

    logic [NP-1:0] r_vld;
    logic [NP-1:0] n_vld;
    t_pipe         r_st [NP];
    t_pipe         n_st [NP];
    logic          r_out_vld;
    t_rsp          r_rsp;
    t_rsp          n_rsp;
    logic [NP:0]   w_adv;

    // Each stage may load when it is empty or its content moves on.
    always_comb begin
        w_adv[NP] = !r_out_vld || i_ready;
        for (int k = NP - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign n_vld   = {r_vld[NP-2:0], i_valid};
    assign o_ready = w_adv[0];
    assign o_valid = r_out_vld;
    assign o_rsp   = r_rsp;

    // Stage 0: offset the integer degrees by whole turns and multiply by 1/90.
    logic signed [H_W-1:0]   w_h;
    logic signed [U_W:0]     w_u_s;
    logic [U_W-1:0]          w_u;
    logic [2*U_W-1:0]        w_prod;

    always_comb begin
        w_h    = i_req.param_a[DATA_W-1:FRAC_BITS];
        w_u_s  = (U_W+1)'(w_h) + (U_W+1)'(ANG_OFS);
        w_u    = w_u_s[U_W-1:0];
        w_prod = (2*U_W)'(w_u) * (2*U_W)'(RECIP);
        n_st[0]     = '0;
        n_st[0].cmd = i_req.command;
        n_st[0].a   = i_req.param_a;
        n_st[0].b   = i_req.param_b;
        n_st[0].u   = w_u;
        n_st[0].q   = Q_W'(w_prod >> RECIP_SH);
    end

    // Stage 1: correct the quotient, split off the quadrant and start the CORDIC.
    logic [U_W-1:0] w_rem;
    logic [R_W-1:0] w_r;
    logic [Q_W-1:0] w_q;

    always_comb begin
        w_rem = r_st[0].u - U_W'(r_st[0].q) * U_W'(90);
        if (w_rem >= U_W'(90)) begin
            w_r = R_W'(w_rem - U_W'(90));
            w_q = r_st[0].q + Q_W'(1);
        end else begin
            w_r = R_W'(w_rem);
            w_q = r_st[0].q;
        end
        n_st[1]      = r_st[0];
        n_st[1].q    = w_q;
        n_st[1].quad = w_q[1:0];
        n_st[1].z    = $signed(Z_W'({w_r, r_st[0].a[FRAC_BITS-1:0]}))
                       <<< (ANG_FRAC - FRAC_BITS);
        n_st[1].x    = XY_W'(X_INIT);
        n_st[1].y    = '0;
    end

    // Stages 2 onward: one rotation-mode CORDIC step each.
    for (genvar k = 2; k < NP; k++) begin : g_cordic
        logic signed [XY_W-1:0] w_dx;
        logic signed [XY_W-1:0] w_dy;

        always_comb begin
            n_st[k] = r_st[k-1];
            w_dx    = r_st[k-1].y >>> (k - 2);
            w_dy    = r_st[k-1].x >>> (k - 2);
            if (!r_st[k-1].z[Z_W-1]) begin
                n_st[k].x = r_st[k-1].x - w_dx;
                n_st[k].y = r_st[k-1].y + w_dy;
                n_st[k].z = r_st[k-1].z - atan_deg(k - 2);
            end else begin
                n_st[k].x = r_st[k-1].x + w_dx;
                n_st[k].y = r_st[k-1].y - w_dy;
                n_st[k].z = r_st[k-1].z + atan_deg(k - 2);
            end
        end
    end

    // Output stage: apply the quadrant, round to the request format, build the rows.
    logic signed [XY_W-1:0]   w_c;
    logic signed [XY_W-1:0]   w_s;
    logic signed [XY_W:0]     w_c_rnd;
    logic signed [XY_W:0]     w_s_rnd;
    logic signed [DATA_W-1:0] w_c_io;
    logic signed [DATA_W-1:0] w_s_io;

    always_comb begin
        case (r_st[NP-1].quad)
            2'd0: begin
                w_c = r_st[NP-1].x;
                w_s = r_st[NP-1].y;
            end
            2'd1: begin
                w_c = -r_st[NP-1].y;
                w_s = r_st[NP-1].x;
            end
            2'd2: begin
                w_c = -r_st[NP-1].x;
                w_s = -r_st[NP-1].y;
            end
            default: begin
                w_c = r_st[NP-1].y;
                w_s = -r_st[NP-1].x;
            end
        endcase
        w_c_rnd = (XY_W+1)'(w_c) + (XY_W+1)'(RND);
        w_s_rnd = (XY_W+1)'(w_s) + (XY_W+1)'(RND);
        w_c_io  = DATA_W'(w_c_rnd >>> OUT_SH);
        w_s_io  = DATA_W'(w_s_rnd >>> OUT_SH);

        n_rsp = '{row0_col0: ONE, row0_col1: '0, row0_col2: '0,
                  row1_col0: '0, row1_col1: ONE, row1_col2: '0};
        case (t_cmd'(r_st[NP-1].cmd))
            CMD_TRANSLATE: begin
                n_rsp.row0_col2 = r_st[NP-1].a;
                n_rsp.row1_col2 = r_st[NP-1].b;
            end
            CMD_ROTATE: begin
                n_rsp.row0_col0 = w_c_io;
                n_rsp.row0_col1 = -w_s_io;
                n_rsp.row1_col0 = w_s_io;
                n_rsp.row1_col1 = w_c_io;
            end
            CMD_SCALE: begin
                n_rsp.row0_col0 = r_st[NP-1].a;
                n_rsp.row1_col1 = r_st[NP-1].b;
            end
            default: begin
                // Unused code: identity rows.
                n_rsp.row0_col0 = ONE;
            end
        endcase
    end

    // Valid bits of the stages and of the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            for (int k = 0; k < NP; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
            if (w_adv[NP]) begin
                r_out_vld <= r_vld[NP-1];
            end
        end
    end

    // Stage data and output register.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NP; k++) begin
            if (w_adv[k]) begin
                r_st[k] <= n_st[k];
            end
        end
        if (w_adv[NP]) begin
            r_rsp <= n_rsp;
        end
    end

`ifndef SYNTHESIS
    // The request side only stalls when every stage and the output are full.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_out_vld && (&r_vld)))
        else $error("request side stalled with a free pipeline stage");

    // The reduced angle lies in the first quadrant.
    a_angle_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (!r_st[1].z[Z_W-1] && (r_st[1].z < QUARTER_Z)))
        else $error("reduced angle outside [0, 90) degrees");

    // A request in the last CORDIC stage is held while the output register is blocked.
    a_last_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NP-1] && !w_adv[NP]) |=> (r_vld[NP-1] && $stable(r_st[NP-1])))
        else $error("last stage lost or changed a stalled request");
`endif

endmodule
